/* rtl/psf2utp_pkg.sv */
package psf2utp_pkg;

   localparam int unsigned GLYPH_INDEX_BITS_DEFAULT = 16;
   localparam int unsigned GLYPH_NUMBER_BITS = 16;
   localparam int unsigned CODE_POINT_BITS = 21;
   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned CSR_DATA_BITS = 16;

   localparam logic [CSR_DATA_BITS-1:0] GLYPH_COUNT_RESET = 16'd512;
   localparam logic [CODE_POINT_BITS-1:0] CODE_POINT_LIMIT = 21'h110000;

   localparam logic [BYTE_BITS-1:0] GLYPH_END_BYTE = 8'hFF;
   localparam logic [BYTE_BITS-1:0] LEAD2_MASK = 8'h1F;
   localparam logic [BYTE_BITS-1:0] LEAD3_MASK = 8'h0F;
   localparam logic [BYTE_BITS-1:0] LEAD4_MASK = 8'h07;
   localparam logic [BYTE_BITS-1:0] CONT_MASK = 8'h3F;

   localparam logic [1:0] PENDING_NONE = 2'd0;
   localparam logic [1:0] PENDING_ONE = 2'd1;
   localparam logic [1:0] PENDING_TWO = 2'd2;
   localparam logic [1:0] PENDING_THREE = 2'd3;

   typedef struct packed {
      logic [CODE_POINT_BITS-1:0] code_accumulator;
      logic [1:0]                 bytes_pending;
      logic                       table_finished;
   } parser_state_type;

   typedef struct packed {
      logic                       valid;
      logic [CODE_POINT_BITS-1:0] code_point;
   } decode_result_type;

endpackage

/* rtl/psf2utp_if.sv */
interface psf2utp_req_if;
   logic                              valid;
   logic                              ready;
   logic [psf2utp_pkg::BYTE_BITS-1:0] table_byte;
   logic                              first_byte;
   logic                              last_byte;

   modport source (output valid, output table_byte, output first_byte, output last_byte,
                   input ready);
   modport sink (input valid, input table_byte, input first_byte, input last_byte,
                 output ready);
endinterface

interface psf2utp_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [psf2utp_pkg::CODE_POINT_BITS-1:0]   code_point;
   logic [psf2utp_pkg::GLYPH_NUMBER_BITS-1:0] glyph_number;

   modport source (output valid, output code_point, output glyph_number, input ready);
   modport sink (input valid, input code_point, input glyph_number, output ready);
endinterface

interface psf2utp_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [psf2utp_pkg::CSR_DATA_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/psf2utp_decode.sv */
module psf2utp_decode #(
   parameter int unsigned GLYPH_INDEX_BITS = psf2utp_pkg::GLYPH_INDEX_BITS_DEFAULT
) (
   input  logic [psf2utp_pkg::BYTE_BITS-1:0] table_byte,
   input  logic                              first_byte,
   input  logic                              last_byte,
   input  psf2utp_pkg::parser_state_type     state_cur,
   input  logic [GLYPH_INDEX_BITS-1:0]       glyph_counter_cur,
   input  logic [GLYPH_INDEX_BITS-1:0]       glyph_count,
   output psf2utp_pkg::parser_state_type     state_nxt,
   output logic [GLYPH_INDEX_BITS-1:0]       glyph_counter_nxt,
   output psf2utp_pkg::decode_result_type    result,
   output logic [GLYPH_INDEX_BITS-1:0]       result_glyph
);
   import psf2utp_pkg::*;

   parser_state_type           st;
   logic [GLYPH_INDEX_BITS-1:0] cnt;
   logic [CODE_POINT_BITS-1:0]  acc_shift;
   logic [1:0]                  pend_dec;

   always_comb begin
      // start of table wipes the parser before this byte
      st        = first_byte ? '0 : state_cur;
      cnt       = first_byte ? '0 : glyph_counter_cur;
      acc_shift = {st.code_accumulator[CODE_POINT_BITS-7:0], table_byte[5:0]};
      pend_dec  = st.bytes_pending - 2'd1;

      state_nxt         = st;
      glyph_counter_nxt = cnt;
      result.valid      = 1'b0;
      result.code_point = '0;
      result_glyph      = cnt;

      if (!st.table_finished) begin
         if (st.bytes_pending != PENDING_NONE) begin
            state_nxt.bytes_pending = pend_dec;
            if (pend_dec == PENDING_NONE) begin
               result.valid               = (acc_shift < CODE_POINT_LIMIT);
               result.code_point          = acc_shift;
               state_nxt.code_accumulator = '0;
            end else begin
               state_nxt.code_accumulator = acc_shift;
            end
         end else if (cnt < glyph_count) begin
            priority if (table_byte == GLYPH_END_BYTE) begin
               glyph_counter_nxt = cnt + GLYPH_INDEX_BITS'(1);
            end else if (!table_byte[7]) begin
               result.valid      = 1'b1;
               result.code_point = CODE_POINT_BITS'(table_byte);
            end else if (!table_byte[5]) begin
               state_nxt.code_accumulator = CODE_POINT_BITS'(table_byte & LEAD2_MASK);
               state_nxt.bytes_pending    = PENDING_ONE;
            end else if (!table_byte[4]) begin
               state_nxt.code_accumulator = CODE_POINT_BITS'(table_byte & LEAD3_MASK);
               state_nxt.bytes_pending    = PENDING_TWO;
            end else if (!table_byte[3]) begin
               state_nxt.code_accumulator = CODE_POINT_BITS'(table_byte & LEAD4_MASK);
               state_nxt.bytes_pending    = PENDING_THREE;
            end else begin
               // unknown lead decodes to code point zero
               result.valid      = 1'b1;
               result.code_point = '0;
            end
         end
      end

      // end of table drops any partial sequence
      if (last_byte) begin
         state_nxt.code_accumulator = '0;
         state_nxt.bytes_pending    = PENDING_NONE;
         state_nxt.table_finished   = 1'b1;
      end
   end

endmodule

/* rtl/psf2_unicode_table_parser_top.sv */
// psf2 unicode table parser: takes the unicode table of a psf2 font one byte per item on
// req_if and gives one item on rsp_if for each code point it completes, carrying the code
// point and the glyph number it belongs to. byte 0xff at a lead position closes a glyph;
// leads are decoded by bits 7, 5, 4 and 3 with no prefix checks, continuation bytes add
// their low six bits, other leads decode to 0, and code points at or above 0x110000 are
// dropped. first_byte clears the parser before its byte, last_byte drops any partial
// sequence and ignores all bytes until the next first_byte. parsing stops once the glyph
// counter reaches glyph_count (csr_if, reset 512, low GLYPH_INDEX_BITS bits kept); write it
// only while the block is idle. one byte can be accepted every cycle: the decode is a single
// pass of masks and a compare between the parser state registers and the result register.
// req_if ready drops only while a result item waits in the result register and rsp_if is
// not ready; the cycle rsp_if takes it, the next byte is accepted alongside.
// a result item is registered and appears in the cycle after its byte is accepted. there is no clearing pass after
// reset.
module psf2_unicode_table_parser_top #(
   parameter int unsigned GLYPH_INDEX_BITS = psf2utp_pkg::GLYPH_INDEX_BITS_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   psf2utp_req_if.sink   req_if,
   psf2utp_rsp_if.source rsp_if,
   psf2utp_csr_if.sink   csr_if
);
   import psf2utp_pkg::*;

   // configuration
   logic [GLYPH_INDEX_BITS-1:0] glyph_count_ff;

   // parser state
   parser_state_type            state_ff;
   parser_state_type            state_in;
   logic [GLYPH_INDEX_BITS-1:0] glyph_counter_ff;
   logic [GLYPH_INDEX_BITS-1:0] glyph_counter_in;

   // decode outputs
   decode_result_type           result;
   logic [GLYPH_INDEX_BITS-1:0] result_glyph;

   // result register
   logic                         rsp_valid_ff;
   logic [CODE_POINT_BITS-1:0]   rsp_code_point_ff;
   logic [GLYPH_NUMBER_BITS-1:0] rsp_glyph_number_ff;

   logic req_take;

   // the block takes a byte whenever the result register is empty or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;

   // configuration writes never stall
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_count_ff <= GLYPH_COUNT_RESET[GLYPH_INDEX_BITS-1:0];
      end else if (csr_if.valid) begin
         glyph_count_ff <= csr_if.data[GLYPH_INDEX_BITS-1:0];
      end
   end

   psf2utp_decode #(
      .GLYPH_INDEX_BITS (GLYPH_INDEX_BITS)
   ) u_decode (
      .table_byte        (req_if.table_byte),
      .first_byte        (req_if.first_byte),
      .last_byte         (req_if.last_byte),
      .state_cur         (state_ff),
      .glyph_counter_cur (glyph_counter_ff),
      .glyph_count       (glyph_count_ff),
      .state_nxt         (state_in),
      .glyph_counter_nxt (glyph_counter_in),
      .result            (result),
      .result_glyph      (result_glyph)
   );

   // parser state advances on every accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= '0;
         glyph_counter_ff <= '0;
      end else if (req_take) begin
         state_ff         <= state_in;
         glyph_counter_ff <= glyph_counter_in;
      end
   end

   // result register: loaded with each accepted byte, emptied when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && result.valid) begin
         rsp_code_point_ff   <= result.code_point;
         rsp_glyph_number_ff <= GLYPH_NUMBER_BITS'(result_glyph);
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.code_point   = rsp_code_point_ff;
   assign rsp_if.glyph_number = rsp_glyph_number_ff;

endmodule

/* rtl/psf2utp_checker.sv */
module psf2utp_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_valid,
   input logic                                      req_ready,
   input logic                                      rsp_valid,
   input logic                                      rsp_ready,
   input logic [psf2utp_pkg::CODE_POINT_BITS-1:0]   rsp_code_point,
   input logic [psf2utp_pkg::GLYPH_NUMBER_BITS-1:0] rsp_glyph_number
);
   import psf2utp_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_point)
                                 && $stable(rsp_glyph_number))
      else $error("result item changed while stalled");

   // only valid code points leave the block
   a_cp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_code_point < CODE_POINT_LIMIT)
      else $error("code point out of range");

   // a new result item needs an accepted byte in the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result item without accepted byte");

   // empty result register never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind psf2_unicode_table_parser_top psf2utp_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_code_point   (rsp_if.code_point),
   .rsp_glyph_number (rsp_if.glyph_number)
);
